/* rtl/dmm_pkg.sv */
// Shared types and constants of the dyadic matrix multiply block.
// Beat payload structs, the controller-to-datapath command record and the returned status record.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package dmm_pkg;

    localparam int IN_W      = 16;
    localparam int C_W       = 38;
    localparam int IDX_W     = 6;
    localparam int LOG_W     = 3;
    localparam int LOG_CAP   = 6;
    localparam logic [LOG_W-1:0] LOG_RESET = 3'd3;

    typedef struct packed {
        logic signed [IN_W-1:0] a_elem;
        logic signed [IN_W-1:0] b_elem;
    } load_beat_t;

    typedef struct packed {
        logic signed [C_W-1:0] c_elem;
        logic [IDX_W-1:0]      c_index;
        logic                  last_out;
    } result_beat_t;

    typedef struct packed {
        logic             load_we;
        logic [IDX_W-1:0] load_addr;
        logic             rd_en;
        logic [IDX_W-1:0] rd_addr_a;
        logic [IDX_W-1:0] rd_addr_b;
        logic             first;
        logic             emit;
        logic             emit_last;
        logic [IDX_W-1:0] emit_index;
    } dmm_cmd_t;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } dmm_stat_t;

endpackage

`default_nettype wire

/* rtl/dmm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module dmm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                                     clk,
    input  wire logic                                     we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                         wdata,
    input  wire logic                                     re,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                              rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* rtl/dmm_datapath.sv */
// Datapath: row stores, multiply-accumulate pipeline and result output register.
// Depends on dmm_pkg and dmm_ram; driven by dmm_ctrl commands.
`timescale 1ns / 1ps
`default_nettype none

module dmm_datapath #(
    parameter int MAX_SIZE   = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire dmm_pkg::dmm_cmd_t     cmd,
    output dmm_pkg::dmm_stat_t         stat,
    input  wire dmm_pkg::load_beat_t   load_beat,
    output logic                       result_valid,
    input  wire logic                  result_ready,
    output dmm_pkg::result_beat_t      result_beat
);

    localparam int LOG_MAX = $clog2(MAX_SIZE + 1) - 1;
    localparam int DEPTH   = 1 << LOG_MAX;
    localparam int AW      = (LOG_MAX > 0) ? LOG_MAX : 1;
    localparam int PW      = 2 * ELEM_WIDTH;

    logic [ELEM_WIDTH-1:0]         a_rdata;
    logic [ELEM_WIDTH-1:0]         b_rdata;
    logic                          s1_vld_reg;
    logic                          s1_first_reg;
    logic                          s2_vld_reg;
    logic                          s2_first_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [dmm_pkg::C_W-1:0] acc_reg;
    logic signed [dmm_pkg::C_W-1:0] acc_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;
    dmm_pkg::result_beat_t         out_beat_reg;

    dmm_ram #(
        .WIDTH(ELEM_WIDTH),
        .DEPTH(DEPTH)
    ) u_a_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (cmd.load_addr[AW-1:0]),
        .wdata (ELEM_WIDTH'(load_beat.a_elem)),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr_a[AW-1:0]),
        .rdata (a_rdata)
    );

    dmm_ram #(
        .WIDTH(ELEM_WIDTH),
        .DEPTH(DEPTH)
    ) u_b_ram (
        .clk   (clk),
        .we    (cmd.load_we),
        .waddr (cmd.load_addr[AW-1:0]),
        .wdata (ELEM_WIDTH'(load_beat.b_elem)),
        .re    (cmd.rd_en),
        .raddr (cmd.rd_addr_b[AW-1:0]),
        .rdata (b_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg    <= 1'b0;
            s2_vld_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg    <= cmd.rd_en;
            s2_vld_reg    <= s1_vld_reg;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        acc_next = (s2_first_reg ? '0 : acc_reg) + dmm_pkg::C_W'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        s1_first_reg <= cmd.first;
        s2_first_reg <= s1_first_reg;
        if (s1_vld_reg)
        begin
            prod_reg <= $signed(a_rdata) * $signed(b_rdata);
        end
        if (s2_vld_reg)
        begin
            acc_reg <= acc_next;
        end
        if (cmd.emit)
        begin
            out_beat_reg.c_elem   <= acc_reg;
            out_beat_reg.c_index  <= cmd.emit_index;
            out_beat_reg.last_out <= cmd.emit_last;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign stat.pipe_busy = s1_vld_reg | s2_vld_reg;
    assign stat.out_free  = !out_valid_reg || result_ready;
    assign result_valid   = out_valid_reg;
    assign result_beat    = out_beat_reg;

endmodule

`default_nettype wire

/* rtl/dmm_ctrl.sv */
// Controller: size register, load counter and the issue/drain/emit sequencer.
// Depends on dmm_pkg; commands dmm_datapath.
`timescale 1ns / 1ps
`default_nettype none

module dmm_ctrl #(
    parameter int MAX_SIZE = 64
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [dmm_pkg::LOG_W-1:0]   cfg_data,
    input  wire logic                        load_valid,
    output logic                             load_ready,
    output dmm_pkg::dmm_cmd_t                cmd,
    input  wire dmm_pkg::dmm_stat_t          stat
);

    localparam int LOG_MAX = $clog2(MAX_SIZE + 1) - 1;
    localparam int AW      = (LOG_MAX > 0) ? LOG_MAX : 1;

    typedef enum logic [3:0] {
        S_LOAD  = 4'b0001,
        S_ISSUE = 4'b0010,
        S_DRAIN = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    state_t                      state_reg;
    state_t                      state_next;
    logic [dmm_pkg::LOG_W-1:0]   log_size_reg;
    logic [dmm_pkg::LOG_W-1:0]   log_size_next;
    logic [AW-1:0]               load_cnt_reg;
    logic [AW-1:0]               load_cnt_next;
    logic [AW-1:0]               i_reg;
    logic [AW-1:0]               i_next;
    logic [AW-1:0]               k_reg;
    logic [AW-1:0]               k_next;
    logic [dmm_pkg::LOG_W-1:0]   eff_log;
    logic [AW:0]                 size_n;
    logic [AW-1:0]               last_idx;
    logic                        cfg_wr;
    logic                        load_acc;

    assign cfg_ready  = 1'b1;
    assign cfg_wr     = cfg_valid && cfg_ready;
    assign load_ready = (state_reg == S_LOAD);
    assign load_acc   = load_valid && load_ready;

    always_comb
    begin
        eff_log  = (log_size_reg > dmm_pkg::LOG_W'(LOG_MAX))
                 ? dmm_pkg::LOG_W'(LOG_MAX) : log_size_reg;
        size_n   = (AW + 1)'(1) << eff_log;
        last_idx = AW'(size_n - (AW + 1)'(1));
    end

    always_comb
    begin
        state_next    = state_reg;
        log_size_next = log_size_reg;
        load_cnt_next = load_cnt_reg;
        i_next        = i_reg;
        k_next        = k_reg;
        cmd           = '0;
        cmd.load_addr = dmm_pkg::IDX_W'(load_cnt_reg);
        cmd.rd_addr_a = dmm_pkg::IDX_W'(i_reg);
        cmd.rd_addr_b = dmm_pkg::IDX_W'(i_reg ^ k_reg);
        cmd.first     = (i_reg == '0);
        cmd.emit_last = (k_reg == last_idx);
        cmd.emit_index = dmm_pkg::IDX_W'(k_reg);

        unique case (state_reg)
            S_LOAD:
            begin
                if (load_acc)
                begin
                    cmd.load_we = 1'b1;
                    if (load_cnt_reg == last_idx)
                    begin
                        load_cnt_next = '0;
                        i_next        = '0;
                        k_next        = '0;
                        state_next    = S_ISSUE;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + AW'(1);
                    end
                end
            end
            S_ISSUE:
            begin
                cmd.rd_en = 1'b1;
                if (i_reg == last_idx)
                begin
                    i_next     = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    i_next = i_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                if (!stat.pipe_busy)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit = 1'b1;
                    if (k_reg == last_idx)
                    begin
                        k_next     = '0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        k_next     = k_reg + AW'(1);
                        state_next = S_ISSUE;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase

        if (cfg_wr)
        begin
            log_size_next = cfg_data;
            load_cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_LOAD;
            log_size_reg <= dmm_pkg::LOG_RESET;
            load_cnt_reg <= '0;
            i_reg        <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            log_size_reg <= log_size_next;
            load_cnt_reg <= load_cnt_next;
            i_reg        <= i_next;
            k_reg        <= k_next;
        end
    end

    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result emitted while output register occupied");

    a_emit_after_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> !stat.pipe_busy)
        else $error("accumulator read before pipeline drained");

    a_last_returns_to_load: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && cmd.emit_last) |=> load_ready)
        else $error("final result did not reopen loading");

    a_full_row_starts_issue: assert property (@(posedge clk) disable iff (!rst_n)
        (load_acc && (load_cnt_reg == last_idx) && !cfg_wr) |=> (state_reg == S_ISSUE))
        else $error("completed row did not start the product");

endmodule

`default_nettype wire

/* rtl/dyadic_matrix_multiply.sv */
// Top level of the dyadic (XOR) matrix multiply block: first-row product c = a (*) b.
// Depends on dmm_pkg, dmm_ctrl, dmm_datapath, dmm_ram.
//
//   channel  | handshake                    | payload
//   ---------+------------------------------+-----------------------------------
//   cfg      | cfg_valid / cfg_ready        | cfg_data: log_size
//   load     | load_valid / load_ready      | load_beat: a_elem, b_elem
//   result   | result_valid / result_ready  | result_beat: c_elem, c_index, last_out
//
// With N = 2^log_size (capped at the store depth), the beat that completes a row of N
// starts the work: one shared multiply-accumulate fed by the two row RAMs, one term per
// cycle, plus drain and emit per result.
// Loading stalls until the last result of the row enters the output register.
// Reset sets log_size to 3 and the load count to 0; row RAM contents are undefined.
`timescale 1ns / 1ps
`default_nettype none

module dyadic_matrix_multiply #(
    parameter int MAX_SIZE   = 64,
    parameter int ELEM_WIDTH = 16
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       cfg_valid,
    output logic                            cfg_ready,
    input  wire logic [dmm_pkg::LOG_W-1:0]  cfg_data,
    input  wire logic                       load_valid,
    output logic                            load_ready,
    input  wire dmm_pkg::load_beat_t        load_beat,
    output logic                            result_valid,
    input  wire logic                       result_ready,
    output dmm_pkg::result_beat_t           result_beat
);

    dmm_pkg::dmm_cmd_t  cmd;
    dmm_pkg::dmm_stat_t stat;

    dmm_ctrl #(
        .MAX_SIZE(MAX_SIZE)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .load_valid (load_valid),
        .load_ready (load_ready),
        .cmd        (cmd),
        .stat       (stat)
    );

    dmm_datapath #(
        .MAX_SIZE  (MAX_SIZE),
        .ELEM_WIDTH(ELEM_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .load_beat    (load_beat),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result_beat  (result_beat)
    );

endmodule

`default_nettype wire
